// ----- rtl/sjf_pkg.sv -----
// Shared types, widths and defaults for the shortest-job-first scheduler.
package sjf_pkg;

    localparam int MAX_JOBS_DEF   = 32;
    localparam int BURST_BITS_DEF = 16;

    localparam int ID_W    = 6;
    localparam int BURST_W = 16;
    localparam int TIME_W  = 21;
    localparam int SUM_W   = 26;

    typedef struct packed {
        logic [BURST_W-1:0] burst_time;
        logic               last_job;
    } t_in;

    typedef struct packed {
        logic [ID_W-1:0]    job_id;
        logic [BURST_W-1:0] job_burst;
        logic [TIME_W-1:0]  wait_time;
        logic [TIME_W-1:0]  turnaround_time;
        logic [SUM_W-1:0]   total_wait;
        logic [SUM_W-1:0]   total_turnaround;
        logic [ID_W-1:0]    job_count;
        logic               overflow_flag;
        logic               final_result;
    } t_out;

    typedef struct packed {
        logic insert;
        logic pop;
    } t_cell_ctl;

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_EMIT = 1'b1;

endpackage

// ----- rtl/sjf_schedule_times.sv -----
// Top level of the shortest-job-first scheduler: job row, batch control and result stage.
// Jobs are taken one per cycle and slotted straight into a row of MAX_JOBS cells that keeps
// them ordered by ascending burst, with equal bursts in arrival order. The transfer marked
// last ends the batch: from the next cycle the row shifts one job per cycle into the result
// stage while the output is not stalled, so a batch of N stored jobs gives N results, and
// no input is taken until the last result has left the row. Jobs beyond MAX_JOBS are
// dropped and reported through the overflow flag of that batch.
module sjf_schedule_times #(
    parameter int MAX_JOBS   = sjf_pkg::MAX_JOBS_DEF,
    parameter int BURST_BITS = sjf_pkg::BURST_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sjf_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output sjf_pkg::t_out o_out_data
);
    import sjf_pkg::*;

    localparam int CW = $clog2(MAX_JOBS + 1);

    logic                  r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_dropped, n_dropped;
    logic [CW-1:0]         r_remaining, n_remaining;
    logic [CW-1:0]         r_batch_count, n_batch_count;
    logic                  r_batch_dropped, n_batch_dropped;

    logic                  accept;
    logic                  full;
    logic                  out_free;
    logic                  pop;
    t_cell_ctl             ctl;
    logic [BURST_BITS+BURST_W-1:0] in_ext;
    logic [BURST_BITS-1:0] new_burst;
    logic [CW-1:0]         new_id;

    logic [BURST_BITS-1:0] cell_burst [MAX_JOBS];
    logic [CW-1:0]         cell_id    [MAX_JOBS];
    logic                  cell_take  [MAX_JOBS];

    assign o_in_stall = (r_state == ST_EMIT);
    assign accept     = i_in_valid && !o_in_stall;
    assign full       = (r_count == CW'(MAX_JOBS));
    assign in_ext     = {{BURST_BITS{1'b0}}, i_in_data.burst_time};
    assign new_burst  = in_ext[BURST_BITS-1:0];
    assign new_id     = r_count + CW'(1);
    assign out_free   = !o_out_valid || !i_out_stall;
    assign pop        = (r_state == ST_EMIT) && out_free;
    assign ctl.insert = accept && !full;
    assign ctl.pop    = pop;

    for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
        logic                  left_take;
        logic [BURST_BITS-1:0] left_burst;
        logic [CW-1:0]         left_id;
        logic [BURST_BITS-1:0] right_burst;
        logic [CW-1:0]         right_id;

        if (g == 0) begin : g_first
            assign left_take  = 1'b0;
            assign left_burst = new_burst;
            assign left_id    = new_id;
        end else begin : g_mid
            assign left_take  = cell_take[g-1];
            assign left_burst = cell_burst[g-1];
            assign left_id    = cell_id[g-1];
        end

        if (g == MAX_JOBS - 1) begin : g_last
            assign right_burst = cell_burst[g];
            assign right_id    = cell_id[g];
        end else begin : g_inner
            assign right_burst = cell_burst[g+1];
            assign right_id    = cell_id[g+1];
        end

        sjf_cell #(
            .BW (BURST_BITS),
            .IW (CW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_occupied    (r_count > CW'(g)),
            .i_new_burst   (new_burst),
            .i_new_id      (new_id),
            .i_left_take   (left_take),
            .i_left_burst  (left_burst),
            .i_left_id     (left_id),
            .i_right_burst (right_burst),
            .i_right_id    (right_id),
            .o_take        (cell_take[g]),
            .o_burst       (cell_burst[g]),
            .o_id          (cell_id[g])
        );
    end

    always_comb begin
        n_state         = r_state;
        n_count         = r_count;
        n_dropped       = r_dropped;
        n_remaining     = r_remaining;
        n_batch_count   = r_batch_count;
        n_batch_dropped = r_batch_dropped;
        case (r_state)
            ST_LOAD: begin
                if (accept) begin
                    if (full) begin
                        n_dropped = 1'b1;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                    if (i_in_data.last_job) begin
                        n_state         = ST_EMIT;
                        n_remaining     = n_count;
                        n_batch_count   = n_count;
                        n_batch_dropped = n_dropped;
                        n_count         = '0;
                        n_dropped       = 1'b0;
                    end
                end
            end
            ST_EMIT: begin
                if (pop) begin
                    n_remaining = r_remaining - CW'(1);
                    if (r_remaining == CW'(1)) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_remaining <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dropped   <= n_dropped;
            r_remaining <= n_remaining;
        end
        r_batch_count   <= n_batch_count;
        r_batch_dropped <= n_batch_dropped;
    end

    sjf_emit #(
        .BW (BURST_BITS),
        .IW (CW)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop       (pop),
        .i_burst     (cell_burst[0]),
        .i_id        (cell_id[0]),
        .i_count     (r_batch_count),
        .i_dropped   (r_batch_dropped),
        .i_final     (r_remaining == CW'(1)),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- rtl/sjf_cell.sv -----
// One cell of the sorted job row: holds a burst and its identifier.
module sjf_cell #(
    parameter int BW = 16,
    parameter int IW = 6
) (
    input  logic                  i_clk,
    input  sjf_pkg::t_cell_ctl    i_ctl,
    input  logic                  i_occupied,
    input  logic [BW-1:0]         i_new_burst,
    input  logic [IW-1:0]         i_new_id,
    input  logic                  i_left_take,
    input  logic [BW-1:0]         i_left_burst,
    input  logic [IW-1:0]         i_left_id,
    input  logic [BW-1:0]         i_right_burst,
    input  logic [IW-1:0]         i_right_id,
    output logic                  o_take,
    output logic [BW-1:0]         o_burst,
    output logic [IW-1:0]         o_id
);
    import sjf_pkg::*;

    logic [BW-1:0] r_burst, n_burst;
    logic [IW-1:0] r_id, n_id;

    assign o_take  = !i_occupied || (r_burst > i_new_burst);
    assign o_burst = r_burst;
    assign o_id    = r_id;

    always_comb begin
        n_burst = r_burst;
        n_id    = r_id;
        if (i_ctl.pop) begin
            n_burst = i_right_burst;
            n_id    = i_right_id;
        end else if (i_ctl.insert) begin
            if (i_left_take) begin
                n_burst = i_left_burst;
                n_id    = i_left_id;
            end else if (o_take) begin
                n_burst = i_new_burst;
                n_id    = i_new_id;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_burst <= n_burst;
        r_id    <= n_id;
    end

endmodule

// ----- rtl/sjf_emit.sv -----
// Result stage: accumulates waiting and turnaround times and holds the output register.
module sjf_emit #(
    parameter int BW = 16,
    parameter int IW = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_pop,
    input  logic [BW-1:0]         i_burst,
    input  logic [IW-1:0]         i_id,
    input  logic [IW-1:0]         i_count,
    input  logic                  i_dropped,
    input  logic                  i_final,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output sjf_pkg::t_out         o_out_data
);
    import sjf_pkg::*;

    logic                r_valid, n_valid;
    t_out                r_data, n_data;
    logic [SUM_W-1:0]    r_time, n_time;
    logic [SUM_W-1:0]    r_sum_wait, n_sum_wait;
    logic [SUM_W-1:0]    r_sum_turn, n_sum_turn;
    logic [BW+SUM_W-1:0] burst_sum_ext;
    logic [BW+BURST_W-1:0] burst_out_ext;
    logic [IW+ID_W-1:0]  id_ext;
    logic [IW+ID_W-1:0]  count_ext;
    logic [SUM_W-1:0]    burst_w;
    logic [SUM_W-1:0]    turn;

    assign burst_sum_ext = {{SUM_W{1'b0}}, i_burst};
    assign burst_out_ext = {{BURST_W{1'b0}}, i_burst};
    assign id_ext        = {{ID_W{1'b0}}, i_id};
    assign count_ext     = {{ID_W{1'b0}}, i_count};
    assign burst_w       = burst_sum_ext[SUM_W-1:0];
    assign turn          = r_time + burst_w;

    always_comb begin
        n_valid    = r_valid && i_out_stall;
        n_data     = r_data;
        n_time     = r_time;
        n_sum_wait = r_sum_wait;
        n_sum_turn = r_sum_turn;
        if (i_pop) begin
            n_valid                = 1'b1;
            n_data.job_id          = id_ext[ID_W-1:0];
            n_data.job_burst       = burst_out_ext[BURST_W-1:0];
            n_data.wait_time       = r_time[TIME_W-1:0];
            n_data.turnaround_time = turn[TIME_W-1:0];
            n_data.total_wait      = r_sum_wait + r_time;
            n_data.total_turnaround = r_sum_turn + turn;
            n_data.job_count       = count_ext[ID_W-1:0];
            n_data.overflow_flag   = i_dropped;
            n_data.final_result    = i_final;
            if (i_final) begin
                n_time     = '0;
                n_sum_wait = '0;
                n_sum_turn = '0;
            end else begin
                n_time     = turn;
                n_sum_wait = r_sum_wait + r_time;
                n_sum_turn = r_sum_turn + turn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_time     <= '0;
            r_sum_wait <= '0;
            r_sum_turn <= '0;
        end else begin
            r_valid    <= n_valid;
            r_time     <= n_time;
            r_sum_wait <= n_sum_wait;
            r_sum_turn <= n_sum_turn;
        end
        r_data <= n_data;
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule
